>>> hw/rtl/motor_position_estimator_macros.svh
// Assertion macros for the motor position estimator.
// Included by files that carry concurrent checks; uses the clock and reset ports.
`ifndef MOTOR_POSITION_ESTIMATOR_MACROS_SVH
`define MOTOR_POSITION_ESTIMATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define MPE_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("motor_position_estimator check failed");
`define MPE_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("motor_position_estimator check failed");
`else
`define MPE_ASSERT(label, prop)
`define MPE_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> hw/rtl/mpe_pkg.sv
// Shared widths, constants, register codes and control types of the motor position estimator.
// No dependencies.
package mpe_pkg;

   localparam int unsigned SPEED_W = 9;
   localparam int unsigned DT_W    = 10;
   localparam int unsigned TICK_W  = 16;
   localparam int unsigned POS_W   = 16;
   localparam int unsigned DUTY_W  = 8;
   localparam int unsigned TPU_W   = 16;
   localparam int unsigned DIR_W   = 2;

   localparam int unsigned PROD_A_W = 31;
   localparam int unsigned PROD_B_W = 19;
   localparam int unsigned INNER_W  = 32;
   localparam int unsigned MAG_W    = 31;
   localparam int unsigned DEN_W    = 31;
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned NUM_W    = MAG_W + FRAC_W;
   localparam int unsigned QUOT_W   = 31;
   localparam int unsigned DIV_STEPS = QUOT_W;
   localparam int unsigned CNT_W    = $clog2(DIV_STEPS);
   localparam int unsigned SUM_W    = QUOT_W + 2;

   localparam logic signed [SPEED_W-1:0]  DEADBAND    = 9'sd64;
   localparam logic signed [PROD_A_W-1:0] ENC_GAIN    = 31'sd20000;
   localparam logic signed [INNER_W-1:0]  PWM_GAIN    = 32'sd51;
   localparam logic [DEN_W-1:0]           DEN_GAIN    = 31'd25000;
   localparam logic [POS_W-1:0]           POS_MAX     = 16'd65280;
   localparam logic [POS_W-1:0]           POS_RESET   = 16'd2560;
   localparam logic [POS_W:0]             SNAP_WINDOW = 17'd204;
   localparam logic [DUTY_W-1:0]          DUTY_FULL   = 8'hFF;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_BRAKE = 2'd2;

   localparam logic [DIR_W-1:0] DIR_RESET = 2'b01;
   localparam logic [TPU_W-1:0] TPU_RESET = 16'd256;

   localparam logic FUNC_SET_SPEED = 1'b0;
   localparam logic FUNC_UPDATE    = 1'b1;

   typedef struct packed {
      logic latch;
      logic drive;
      logic mul;
      logic sum;
      logic load;
      logic div_step;
      logic pos;
      logic emit;
   } mpe_cmd_type;

   typedef struct packed {
      logic func;
      logic dt_zero;
   } mpe_sts_type;

endpackage

>>> hw/rtl/motor_position_estimator.sv
// Motor position estimator: H-bridge duty selection and blended encoder/PWM position
// tracking. A set-speed item, or an update with zero dt_ms, passes through EXEC and DONE
// before rsp_valid is registered; an update with nonzero dt_ms passes through EXEC, SUM,
// LOAD, the 31-step restoring divider (DIV), POS and DONE; the divider divides the blended
// distance by ticks_per_unit_q8 times DEN_GAIN. DONE stalls while a prior beat is unaccepted.
// The next item is taken in the cycle after the beat enters the output register. One item
// is in work at a time; the output register holds a finished beat while the next item is taken.
// Registers sit at byte addresses 0x0 (direction), 0x4 (ticks_per_unit_q8), 0x8 (idle_brake).
// Depends on mpe_pkg, mpe_controller, mpe_datapath and the assertion macro header.
`include "motor_position_estimator_macros.svh"

module motor_position_estimator import mpe_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]     csr_prdata,
   output logic                      csr_pready,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic signed [SPEED_W-1:0] req_speed,
   input  logic [DT_W-1:0]           req_dt_ms,
   input  logic [TICK_W-1:0]         req_tick_count,
   input  logic [POS_W-1:0]          req_target,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [DUTY_W-1:0]         rsp_pwm_a,
   output logic [DUTY_W-1:0]         rsp_pwm_b,
   output logic [POS_W-1:0]          rsp_position
);

   logic [DIR_W-1:0]     direction_ff;
   logic [TPU_W-1:0]     tpu_ff;
   logic                 idle_brake_ff;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 duty_pair_ok;
   mpe_cmd_type          cmd;
   mpe_sts_type          sts;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff  <= DIR_RESET;
         tpu_ff        <= TPU_RESET;
         idle_brake_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_idx)
            CSR_DIRECTION:  direction_ff  <= csr_pwdata[DIR_W-1:0];
            CSR_TICKS:      tpu_ff        <= csr_pwdata[TPU_W-1:0];
            CSR_IDLE_BRAKE: idle_brake_ff <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_DIRECTION: begin
            csr_prdata = {{(CSR_DATA_W-DIR_W){direction_ff[DIR_W-1]}}, direction_ff};
         end
         CSR_TICKS:      csr_prdata = CSR_DATA_W'(tpu_ff);
         CSR_IDLE_BRAKE: csr_prdata = CSR_DATA_W'(idle_brake_ff);
         default:        csr_prdata = '0;
      endcase
   end

   mpe_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mpe_datapath u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .cfg_direction         (direction_ff),
      .cfg_ticks_per_unit_q8 (tpu_ff),
      .cfg_idle_brake        (idle_brake_ff),
      .req_func              (req_func),
      .req_speed             (req_speed),
      .req_dt_ms             (req_dt_ms),
      .req_tick_count        (req_tick_count),
      .req_target            (req_target),
      .rsp_pwm_a             (rsp_pwm_a),
      .rsp_pwm_b             (rsp_pwm_b),
      .rsp_position          (rsp_position)
   );

   assign duty_pair_ok = (rsp_pwm_a == '0) || (rsp_pwm_b == '0) ||
                         (rsp_pwm_a == DUTY_FULL && rsp_pwm_b == DUTY_FULL);

   `MPE_ASSERT(a_one_item, (req_valid && req_ready) |=> !req_ready)
   `MPE_ASSERT(a_duty_pair, rsp_valid |-> duty_pair_ok)
   `MPE_ASSERT_ALWAYS(a_reset_clean, $past(reset) |-> (req_ready && !rsp_valid))

endmodule

>>> hw/rtl/mpe_datapath.sv
// Datapath of the motor position estimator: drive duties, blend products, divider, clamp.
// Depends on mpe_pkg; driven by commands from mpe_controller.
module mpe_datapath import mpe_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  mpe_cmd_type               cmd,
   output mpe_sts_type               sts,
   input  logic [DIR_W-1:0]          cfg_direction,
   input  logic [TPU_W-1:0]          cfg_ticks_per_unit_q8,
   input  logic                      cfg_idle_brake,
   input  logic                      req_func,
   input  logic signed [SPEED_W-1:0] req_speed,
   input  logic [DT_W-1:0]           req_dt_ms,
   input  logic [TICK_W-1:0]         req_tick_count,
   input  logic [POS_W-1:0]          req_target,
   output logic [DUTY_W-1:0]         rsp_pwm_a,
   output logic [DUTY_W-1:0]         rsp_pwm_b,
   output logic [POS_W-1:0]          rsp_position
);

   logic                      func_ff;
   logic signed [SPEED_W-1:0] speed_ff;
   logic [DT_W-1:0]           dt_ff;
   logic [TICK_W-1:0]         tick_ff;
   logic [POS_W-1:0]          target_ff;

   logic signed [SPEED_W-1:0] drive_speed_ff, drive_speed_in;
   logic [POS_W-1:0]          position_ff, position_in;
   logic [TICK_W-1:0]         prev_tick_ff, prev_tick_in;
   logic [DUTY_W-1:0]         duty_a_ff, duty_a_in;
   logic [DUTY_W-1:0]         duty_b_ff, duty_b_in;

   logic signed [PROD_A_W-1:0] prod_a_ff;
   logic signed [PROD_B_W-1:0] prod_b_ff;
   logic [DEN_W-1:0]           den_ff;
   logic                       neg_ff;
   logic [MAG_W-1:0]           mag_ff;
   logic [DEN_W-1:0]           rem_ff, rem_in;
   logic [QUOT_W-1:0]          qlow_ff, qlow_in;

   logic [DUTY_W-1:0] out_a_ff;
   logic [DUTY_W-1:0] out_b_ff;
   logic [POS_W-1:0]  out_pos_ff;

   logic signed [SPEED_W:0]    speed_ext;
   logic signed [SPEED_W:0]    hw;
   logic [SPEED_W:0]           hw_mag;
   logic [DUTY_W-1:0]          hw_sat;
   logic signed [SPEED_W-1:0]  s_val;
   logic [TICK_W-1:0]          delta;
   logic signed [PROD_A_W-1:0] delta_ext;
   logic signed [PROD_B_W-1:0] s_ext;
   logic signed [PROD_B_W-1:0] dt_ext;
   logic [TPU_W-1:0]           tpu_eff;
   logic signed [INNER_W-1:0]  a_ext;
   logic signed [INNER_W-1:0]  b_ext;
   logic signed [INNER_W-1:0]  inner;
   logic [INNER_W-1:0]         inner_abs;
   logic [NUM_W-1:0]           num;
   logic [DEN_W:0]             trial;
   logic [DEN_W:0]             trial_sub;
   logic signed [SUM_W-1:0]    pos_sum;
   logic [POS_W-1:0]           pos_clamp;
   logic [POS_W:0]             pos_diff;

   // drive pattern
   always_comb begin
      speed_ext = {speed_ff[SPEED_W-1], speed_ff};
      priority if (cfg_direction[DIR_W-1]) begin
         hw = -speed_ext;
      end else if (cfg_direction != '0) begin
         hw = speed_ext;
      end else begin
         hw = '0;
      end
      hw_mag = hw[SPEED_W] ? unsigned'(-hw) : unsigned'(hw);
      hw_sat = (hw_mag > (SPEED_W+1)'(DUTY_FULL)) ? DUTY_FULL : hw_mag[DUTY_W-1:0];
   end

   // deadband and products
   always_comb begin
      priority if (drive_speed_ff > DEADBAND) begin
         s_val = drive_speed_ff - DEADBAND;
      end else if (drive_speed_ff < -DEADBAND) begin
         s_val = drive_speed_ff + DEADBAND;
      end else begin
         s_val = '0;
      end
      delta     = tick_ff - prev_tick_ff;
      delta_ext = {{(PROD_A_W-TICK_W){delta[TICK_W-1]}}, delta};
      s_ext     = {{(PROD_B_W-SPEED_W){s_val[SPEED_W-1]}}, s_val};
      dt_ext    = {{(PROD_B_W-DT_W){1'b0}}, dt_ff};
      tpu_eff   = (cfg_ticks_per_unit_q8 == '0) ? TPU_W'(1) : cfg_ticks_per_unit_q8;
      a_ext     = {{(INNER_W-PROD_A_W){prod_a_ff[PROD_A_W-1]}}, prod_a_ff};
      b_ext     = {{(INNER_W-PROD_B_W){prod_b_ff[PROD_B_W-1]}}, prod_b_ff};
      inner     = a_ext + b_ext * PWM_GAIN;
      inner_abs = inner[INNER_W-1] ? unsigned'(-inner) : unsigned'(inner);
      num       = {mag_ff, {FRAC_W{1'b0}}} + NUM_W'(den_ff >> 1);
      trial     = {rem_ff, qlow_ff[QUOT_W-1]};
      trial_sub = trial - {1'b0, den_ff};
   end

   // restoring divider step
   always_comb begin
      rem_in  = rem_ff;
      qlow_in = qlow_ff;
      if (cmd.load) begin
         rem_in  = DEN_W'(num[NUM_W-1:QUOT_W]);
         qlow_in = num[QUOT_W-1:0];
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial_sub[DEN_W-1:0];
            qlow_in = {qlow_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DEN_W-1:0];
            qlow_in = {qlow_ff[QUOT_W-2:0], 1'b0};
         end
      end
   end

   // apply step, clamp, snap
   always_comb begin
      if (neg_ff) begin
         pos_sum = SUM_W'({1'b0, position_ff}) - SUM_W'({1'b0, qlow_ff});
      end else begin
         pos_sum = SUM_W'({1'b0, position_ff}) + SUM_W'({1'b0, qlow_ff});
      end
      priority if (pos_sum < 0) begin
         pos_clamp = '0;
      end else if (pos_sum > SUM_W'({1'b0, POS_MAX})) begin
         pos_clamp = POS_MAX;
      end else begin
         pos_clamp = pos_sum[POS_W-1:0];
      end
      pos_diff = (pos_clamp > target_ff) ? {1'b0, pos_clamp} - {1'b0, target_ff}
                                         : {1'b0, target_ff} - {1'b0, pos_clamp};
   end

   always_comb begin
      drive_speed_in = drive_speed_ff;
      duty_a_in      = duty_a_ff;
      duty_b_in      = duty_b_ff;
      prev_tick_in   = prev_tick_ff;
      position_in    = position_ff;
      if (cmd.drive) begin
         drive_speed_in = speed_ff;
         priority if (hw[SPEED_W]) begin
            duty_a_in = '0;
            duty_b_in = hw_sat;
         end else if (hw != '0) begin
            duty_a_in = hw_sat;
            duty_b_in = '0;
         end else if (cfg_idle_brake) begin
            duty_a_in = '0;
            duty_b_in = '0;
         end else begin
            duty_a_in = DUTY_FULL;
            duty_b_in = DUTY_FULL;
         end
      end
      if (cmd.mul) begin
         prev_tick_in = tick_ff;
      end
      if (cmd.pos) begin
         position_in = (pos_diff <= SNAP_WINDOW) ? target_ff : pos_clamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_speed_ff <= '0;
         position_ff    <= POS_RESET;
         prev_tick_ff   <= '0;
         duty_a_ff      <= '0;
         duty_b_ff      <= '0;
      end else begin
         drive_speed_ff <= drive_speed_in;
         position_ff    <= position_in;
         prev_tick_ff   <= prev_tick_in;
         duty_a_ff      <= duty_a_in;
         duty_b_ff      <= duty_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff   <= req_func;
         speed_ff  <= req_speed;
         dt_ff     <= req_dt_ms;
         tick_ff   <= req_tick_count;
         target_ff <= req_target;
      end
      if (cmd.mul) begin
         prod_a_ff <= delta_ext * ENC_GAIN;
         prod_b_ff <= s_ext * dt_ext;
         den_ff    <= DEN_W'(tpu_eff) * DEN_GAIN;
      end
      if (cmd.sum) begin
         neg_ff <= inner[INNER_W-1];
         mag_ff <= inner_abs[MAG_W-1:0];
      end
      rem_ff  <= rem_in;
      qlow_ff <= qlow_in;
      if (cmd.emit) begin
         out_a_ff   <= duty_a_ff;
         out_b_ff   <= duty_b_ff;
         out_pos_ff <= position_ff;
      end
   end

   assign sts.func    = func_ff;
   assign sts.dt_zero = (dt_ff == '0);

   assign rsp_pwm_a    = out_a_ff;
   assign rsp_pwm_b    = out_b_ff;
   assign rsp_position = out_pos_ff;

endmodule

>>> hw/rtl/mpe_controller.sv
// Sequencer of the motor position estimator: handshakes, step order, divider count.
// Depends on mpe_pkg; commands mpe_datapath.
module mpe_controller import mpe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  mpe_sts_type sts,
   output mpe_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_LOAD = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_POS  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            priority if (sts.func == FUNC_SET_SPEED) begin
               cmd.drive = 1'b1;
               state_in  = ST_DONE;
            end else if (sts.dt_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_POS;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_POS: begin
            cmd.pos  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
